@@ rtl/gda_pkg.sv @@
// ----------------------------------------------------------------------------
// gda_pkg
// Shared widths, command codes, reciprocal constants and calendar tables for
// the Gregorian date arithmetic unit.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int unsigned CmdW   = 3;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountW = 22;
  localparam int unsigned AbsW   = 23;
  localparam int unsigned DoyW   = 9;
  localparam int unsigned Q100W  = 8;
  localparam int unsigned WeekW  = 7;

  // p / 100 for p < 2**14 as (p * 5243) >> 19
  localparam int unsigned Div100Mul   = 5243;
  localparam int unsigned Div100MulW  = 13;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned Prod100W    = YearW + Div100MulW;

  // x / 7 for x < 2**9 as (x * 293) >> 11
  localparam int unsigned Div7Mul   = 293;
  localparam int unsigned Div7Shift = 11;
  localparam int unsigned Prod7W    = 20;

  localparam logic [AbsW-1:0] CountMax = AbsW'(4194303);

  typedef enum logic [CmdW-1:0] {
    CMD_NEXT_DAY = 3'd0,
    CMD_PREV_DAY = 3'd1,
    CMD_WEEK     = 3'd2,
    CMD_DIST     = 3'd3,
    CMD_ANNIV    = 3'd4
  } cmd_e;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic leap);
    logic [DayW-1:0] len;
    len = 5'd31;
    if (m == 4'd2) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      len = 5'd30;
    end
    return len;
  endfunction

  // days in the months before month m
  function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] m,
                                               input logic leap);
    logic [DoyW-1:0] base;
    case (m)
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      4'd13:   base = 9'd365;
      4'd14:   base = 9'd396;
      4'd15:   base = 9'd427;
      default: base = 9'd0;
    endcase
    if (leap && (m >= 4'd3)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

endpackage

@@ rtl/gda_req_if.sv @@
// ----------------------------------------------------------------------------
// gda_req_if
// Request channel: command and two dates, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gda_req_if;
  logic                          valid;
  logic                          ready;
  logic [gda_pkg::CmdW-1:0]      cmd;
  logic [gda_pkg::DayW-1:0]      date_day;
  logic [gda_pkg::MonthW-1:0]    date_month;
  logic [gda_pkg::YearW-1:0]     date_year;
  logic [gda_pkg::DayW-1:0]      second_day;
  logic [gda_pkg::MonthW-1:0]    second_month;
  logic [gda_pkg::YearW-1:0]     second_year;

  modport source (
    output valid, cmd, date_day, date_month, date_year,
           second_day, second_month, second_year,
    input  ready
  );
  modport sink (
    input  valid, cmd, date_day, date_month, date_year,
           second_day, second_month, second_year,
    output ready
  );
endinterface

@@ rtl/gda_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gda_rsp_if
// Response channel: stepped date and count, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gda_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [gda_pkg::DayW-1:0]      out_day;
  logic [gda_pkg::MonthW-1:0]    out_month;
  logic [gda_pkg::YearW-1:0]     out_year;
  logic [gda_pkg::CountW-1:0]    out_count;

  modport source (
    output valid, out_day, out_month, out_year, out_count,
    input  ready
  );
  modport sink (
    input  valid, out_day, out_month, out_year, out_count,
    output ready
  );
endinterface

@@ rtl/gregorian_date_arithmetic.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic
// Stateless Gregorian date unit: next/previous day, week number, day
// distance and days to the next anniversary.
//
// Usage:
//   req_i carries a command and two dates; every transfer on req_i gives
//   exactly one transfer on rsp_o, in order.
//   Pipeline: a req_i transfer passes through the five register stages
//   (divide-by-100 reciprocal multiply, leap and quotient, days before
//   year and day of year, absolute day numbers and week divide, difference
//   with saturation into the output register) before rsp_o.valid rises.
//   Throughput: one item per cycle while rsp_o.ready is high; each stage
//   hands over as soon as the next one is empty or moving.
//   Stall: when rsp_o.ready is low the output holds, stages behind it fill
//   up, and req_i.ready drops once all five are occupied. Nothing is lost.
//   Reset: rst_ni clears all stage valid bits; rsp_o.valid goes low and
//   req_i.ready is high right after reset.
//   Commands 0 and 1 return a date and count 0; commands 2 to 4 return
//   date 1/1/0 and a count; unused codes return 1/1/0 and count 0.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic (
  input  logic       clk_i,
  input  logic       rst_ni,
  gda_req_if.sink    req_i,
  gda_rsp_if.source  rsp_o
);

  // handshake enables
  logic s1_en, s2_en, s3_en, s4_en, s5_en;
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, s5_valid_q;

  assign s5_en = !s5_valid_q || rsp_o.ready;
  assign s4_en = !s4_valid_q || s5_en;
  assign s3_en = !s3_valid_q || s4_en;
  assign s2_en = !s2_valid_q || s3_en;
  assign s1_en = !s1_valid_q || s2_en;
  assign req_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= req_i.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
      if (s4_en) s4_valid_q <= s3_valid_q;
      if (s5_en) s5_valid_q <= s4_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: year offsets and reciprocal multiply
  // --------------------------------------------------------------------------
  logic [gda_pkg::YearW-1:0]    pa_d, pb_d;
  logic                         za_d, zb_d;
  logic [gda_pkg::Prod100W-1:0] proda_d, prodb_d;

  always_comb begin
    za_d = (req_i.date_year == '0);
    pa_d = za_d ? '0 : req_i.date_year - 14'd1;
    if (req_i.cmd == gda_pkg::CMD_DIST) begin
      zb_d = (req_i.second_year == '0);
      pb_d = zb_d ? '0 : req_i.second_year - 14'd1;
    end else begin
      // anniversary next year: offset of year y+1 is y
      zb_d = 1'b0;
      pb_d = req_i.date_year;
    end
    proda_d = gda_pkg::Prod100W'(pa_d) * gda_pkg::Prod100W'(gda_pkg::Div100Mul);
    prodb_d = gda_pkg::Prod100W'(pb_d) * gda_pkg::Prod100W'(gda_pkg::Div100Mul);
  end

  logic [gda_pkg::CmdW-1:0]     s1_cmd_q;
  logic [gda_pkg::DayW-1:0]     s1_d_q, s1_sd_q;
  logic [gda_pkg::MonthW-1:0]   s1_m_q, s1_sm_q;
  logic [gda_pkg::YearW-1:0]    s1_y_q, s1_pa_q, s1_pb_q;
  logic                         s1_za_q, s1_zb_q;
  logic [gda_pkg::Prod100W-1:0] s1_proda_q, s1_prodb_q;

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      s1_cmd_q   <= req_i.cmd;
      s1_d_q     <= req_i.date_day;
      s1_m_q     <= req_i.date_month;
      s1_y_q     <= req_i.date_year;
      s1_sd_q    <= req_i.second_day;
      s1_sm_q    <= req_i.second_month;
      s1_pa_q    <= pa_d;
      s1_pb_q    <= pb_d;
      s1_za_q    <= za_d;
      s1_zb_q    <= zb_d;
      s1_proda_q <= proda_d;
      s1_prodb_q <= prodb_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: quotient, remainder and leap flags
  // --------------------------------------------------------------------------
  logic [gda_pkg::Q100W-1:0] qa_d, qb_d;
  logic [6:0]                rema_d, remb_d;
  logic                      leapa_d, leapb_d;

  always_comb begin
    qa_d   = s1_proda_q[gda_pkg::Prod100W-1 -: gda_pkg::Q100W];
    qb_d   = s1_prodb_q[gda_pkg::Prod100W-1 -: gda_pkg::Q100W];
    rema_d = 7'(s1_pa_q - 14'(qa_d * 14'd100));
    remb_d = 7'(s1_pb_q - 14'(qb_d * 14'd100));
    // year = p + 1 is leap when p mod 4 = 3 and not (p mod 100 = 99 unless p mod 400 = 399)
    leapa_d = s1_za_q ||
              ((s1_pa_q[1:0] == 2'b11) && ((rema_d != 7'd99) || (qa_d[1:0] == 2'b11)));
    leapb_d = s1_zb_q ||
              ((s1_pb_q[1:0] == 2'b11) && ((remb_d != 7'd99) || (qb_d[1:0] == 2'b11)));
  end

  logic [gda_pkg::CmdW-1:0]   s2_cmd_q;
  logic [gda_pkg::DayW-1:0]   s2_d_q, s2_sd_q;
  logic [gda_pkg::MonthW-1:0] s2_m_q, s2_sm_q;
  logic [gda_pkg::YearW-1:0]  s2_y_q, s2_pa_q, s2_pb_q;
  logic                       s2_za_q, s2_zb_q, s2_leapa_q, s2_leapb_q;
  logic [gda_pkg::Q100W-1:0]  s2_qa_q, s2_qb_q;
  logic [6:0]                 s2_rema_q;

  always_ff @(posedge clk_i) begin
    if (s2_en) begin
      s2_cmd_q   <= s1_cmd_q;
      s2_d_q     <= s1_d_q;
      s2_m_q     <= s1_m_q;
      s2_y_q     <= s1_y_q;
      s2_sd_q    <= s1_sd_q;
      s2_sm_q    <= s1_sm_q;
      s2_pa_q    <= s1_pa_q;
      s2_pb_q    <= s1_pb_q;
      s2_za_q    <= s1_za_q;
      s2_zb_q    <= s1_zb_q;
      s2_qa_q    <= qa_d;
      s2_qb_q    <= qb_d;
      s2_rema_q  <= rema_d;
      s2_leapa_q <= leapa_d;
      s2_leapb_q <= leapb_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: days before year, day of year, day stepping
  // --------------------------------------------------------------------------
  logic [gda_pkg::AbsW-1:0]   dbya_d, dbyb_d;
  logic [gda_pkg::DoyW-1:0]   doya_d, doysa_d, doysb_d;
  logic [gda_pkg::DayW-1:0]   mlen_d, plen_d, rd_d;
  logic [gda_pkg::MonthW-1:0] pm_d, rm_d;
  logic [gda_pkg::YearW-1:0]  ry_d;

  always_comb begin
    dbya_d = s2_za_q ? '0 :
             23'(s2_pa_q) * 23'd365 + 23'(s2_pa_q[13:2]) - 23'(s2_qa_q) + 23'(s2_qa_q[7:2]);
    dbyb_d = s2_zb_q ? '0 :
             23'(s2_pb_q) * 23'd365 + 23'(s2_pb_q[13:2]) - 23'(s2_qb_q) + 23'(s2_qb_q[7:2]);
    doya_d  = gda_pkg::cum_days(s2_m_q, s2_leapa_q) + 9'(s2_d_q);
    doysa_d = gda_pkg::cum_days(s2_sm_q, s2_leapa_q) + 9'(s2_sd_q);
    doysb_d = gda_pkg::cum_days(s2_sm_q, s2_leapb_q) + 9'(s2_sd_q);

    mlen_d = gda_pkg::month_len(s2_m_q, s2_leapa_q);
    pm_d   = (s2_m_q <= 4'd1) ? 4'd12 : s2_m_q - 4'd1;
    plen_d = gda_pkg::month_len(pm_d, s2_leapa_q);

    rd_d = 5'd1;
    rm_d = 4'd1;
    ry_d = '0;
    case (s2_cmd_q)
      gda_pkg::CMD_NEXT_DAY: begin
        ry_d = s2_y_q;
        if (s2_d_q >= mlen_d) begin
          rd_d = 5'd1;
          if (s2_m_q >= 4'd12) begin
            rm_d = 4'd1;
            ry_d = s2_y_q + 14'd1;
          end else begin
            rm_d = s2_m_q + 4'd1;
          end
        end else begin
          rd_d = s2_d_q + 5'd1;
          rm_d = s2_m_q;
        end
      end
      gda_pkg::CMD_PREV_DAY: begin
        if (s2_d_q <= 5'd1) begin
          rd_d = plen_d;
          rm_d = pm_d;
          ry_d = (s2_m_q <= 4'd1) ? s2_y_q - 14'd1 : s2_y_q;
        end else begin
          rd_d = s2_d_q - 5'd1;
          rm_d = s2_m_q;
          ry_d = s2_y_q;
        end
      end
      default: begin
        rd_d = 5'd1;
        rm_d = 4'd1;
        ry_d = '0;
      end
    endcase
  end

  logic [gda_pkg::CmdW-1:0]   s3_cmd_q;
  logic [gda_pkg::AbsW-1:0]   s3_dbya_q, s3_dbyb_q;
  logic [gda_pkg::DoyW-1:0]   s3_doya_q, s3_doysa_q, s3_doysb_q;
  logic [gda_pkg::DayW-1:0]   s3_rd_q;
  logic [gda_pkg::MonthW-1:0] s3_rm_q;
  logic [gda_pkg::YearW-1:0]  s3_ry_q;

  always_ff @(posedge clk_i) begin
    if (s3_en) begin
      s3_cmd_q   <= s2_cmd_q;
      s3_dbya_q  <= dbya_d;
      s3_dbyb_q  <= dbyb_d;
      s3_doya_q  <= doya_d;
      s3_doysa_q <= doysa_d;
      s3_doysb_q <= doysb_d;
      s3_rd_q    <= rd_d;
      s3_rm_q    <= rm_d;
      s3_ry_q    <= ry_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: absolute day numbers and week number
  // --------------------------------------------------------------------------
  logic [gda_pkg::AbsW-1:0]   absa_d, absb_d;
  logic [gda_pkg::DoyW-1:0]   doym1_d;
  logic [gda_pkg::Prod7W-1:0] prod7_d;
  logic [gda_pkg::WeekW-1:0]  week_d;
  logic                       this_year_d;

  always_comb begin
    absa_d = s3_dbya_q + 23'(s3_doya_q);
    // anniversary stays in this year only when it is still ahead
    this_year_d = (s3_cmd_q == gda_pkg::CMD_ANNIV) && (s3_doysa_q > s3_doya_q);
    absb_d = this_year_d ? s3_dbya_q + 23'(s3_doysa_q) : s3_dbyb_q + 23'(s3_doysb_q);

    doym1_d = s3_doya_q - 9'd1;
    prod7_d = gda_pkg::Prod7W'(doym1_d) * gda_pkg::Prod7W'(gda_pkg::Div7Mul);
    week_d  = (s3_doya_q == '0) ? 7'd1 :
              7'(prod7_d >> gda_pkg::Div7Shift) + 7'd1;
  end

  logic [gda_pkg::CmdW-1:0]   s4_cmd_q;
  logic [gda_pkg::AbsW-1:0]   s4_absa_q, s4_absb_q;
  logic [gda_pkg::WeekW-1:0]  s4_week_q;
  logic [gda_pkg::DayW-1:0]   s4_rd_q;
  logic [gda_pkg::MonthW-1:0] s4_rm_q;
  logic [gda_pkg::YearW-1:0]  s4_ry_q;

  always_ff @(posedge clk_i) begin
    if (s4_en) begin
      s4_cmd_q  <= s3_cmd_q;
      s4_absa_q <= absa_d;
      s4_absb_q <= absb_d;
      s4_week_q <= week_d;
      s4_rd_q   <= s3_rd_q;
      s4_rm_q   <= s3_rm_q;
      s4_ry_q   <= s3_ry_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: difference, saturation, output register
  // --------------------------------------------------------------------------
  logic [gda_pkg::AbsW-1:0]   diff_d;
  logic [gda_pkg::CountW-1:0] cnt_d;

  always_comb begin
    diff_d = (s4_absa_q >= s4_absb_q) ? s4_absa_q - s4_absb_q : s4_absb_q - s4_absa_q;
    case (s4_cmd_q)
      gda_pkg::CMD_WEEK:  cnt_d = 22'(s4_week_q);
      gda_pkg::CMD_DIST,
      gda_pkg::CMD_ANNIV: cnt_d = (diff_d > gda_pkg::CountMax) ?
                                  gda_pkg::CountMax[gda_pkg::CountW-1:0] :
                                  diff_d[gda_pkg::CountW-1:0];
      default:            cnt_d = '0;
    endcase
  end

  logic [gda_pkg::DayW-1:0]   s5_rd_q;
  logic [gda_pkg::MonthW-1:0] s5_rm_q;
  logic [gda_pkg::YearW-1:0]  s5_ry_q;
  logic [gda_pkg::CountW-1:0] s5_cnt_q;

  always_ff @(posedge clk_i) begin
    if (s5_en) begin
      s5_rd_q  <= s4_rd_q;
      s5_rm_q  <= s4_rm_q;
      s5_ry_q  <= s4_ry_q;
      s5_cnt_q <= cnt_d;
    end
  end

  assign rsp_o.valid     = s5_valid_q;
  assign rsp_o.out_day   = s5_rd_q;
  assign rsp_o.out_month = s5_rm_q;
  assign rsp_o.out_year  = s5_ry_q;
  assign rsp_o.out_count = s5_cnt_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_accept_enters_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_valid_q)
    else $error("accepted transfer did not enter stage 1");

  a_s1_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_en) |=> (s1_valid_q && $stable(s1_pa_q)))
    else $error("stage 1 lost its item under stall");

  a_rem100_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (s2_rema_q < 7'd100))
    else $error("divide by 100 remainder out of range");

  a_week_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s4_valid_q && (s4_cmd_q == gda_pkg::CMD_WEEK)) |->
      ((s4_week_q != '0) && (s4_week_q <= 7'd66)))
    else $error("week number out of range");

endmodule

@@ bench/gregorian_date_arithmetic_checker.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_checker
// Watches the request and response channels of the date unit. It predicts
// the date and count for every request transfer, keeps the predictions in
// order, and compares each response transfer field by field with the oldest
// one. It hands the mismatch count and the number of outstanding
// predictions to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gregorian_date_arithmetic_checker (
  input  logic clk_i,
  input  logic rst_ni,
  gda_req_if   req_i,
  gda_rsp_if   rsp_i,
  output int   errors_o,
  output int   pending_o
);

  localparam int unsigned YearSpan  = 1 << gda_pkg::YearW;
  localparam longint unsigned GapMax = (longint'(1) << gda_pkg::CountW) - 1;

  typedef struct packed {
    logic [gda_pkg::DayW-1:0]   day;
    logic [gda_pkg::MonthW-1:0] month;
    logic [gda_pkg::YearW-1:0]  year;
    logic [gda_pkg::CountW-1:0] count;
  } date_result_t;

  date_result_t calendar_results_q[$];
  int mismatch_cnt = 0;
  int outstanding  = 0;

  assign errors_o  = mismatch_cnt;
  assign pending_o = outstanding;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // any month code other than 2, 4, 6, 9 and 11 has 31 days
  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  function automatic int unsigned ordinal_day(int unsigned d, int unsigned m,
                                              int unsigned y);
    int unsigned total;
    int unsigned k;
    total = d;
    for (k = 1; k < m; k++) begin
      total += days_in_month(k, y);
    end
    return total;
  endfunction

  // year 0 has nothing before it
  function automatic longint unsigned day_number(int unsigned d, int unsigned m,
                                                 int unsigned y);
    longint unsigned p;
    longint unsigned prior;
    prior = 0;
    if (y != 0) begin
      p = 64'(y) - 1;
      prior = 365 * p + p / 4 - p / 100 + p / 400;
    end
    return prior + 64'(ordinal_day(d, m, y));
  endfunction

  function automatic logic [gda_pkg::CountW-1:0] day_gap(longint unsigned a,
                                                         longint unsigned b);
    longint unsigned diff;
    diff = (a > b) ? a - b : b - a;
    if (diff > GapMax) begin
      diff = GapMax;
    end
    return gda_pkg::CountW'(diff);
  endfunction

  function automatic date_result_t predict_calendar(
    logic [gda_pkg::CmdW-1:0]   cmd,
    logic [gda_pkg::DayW-1:0]   d,
    logic [gda_pkg::MonthW-1:0] m,
    logic [gda_pkg::YearW-1:0]  y,
    logic [gda_pkg::DayW-1:0]   sd,
    logic [gda_pkg::MonthW-1:0] sm,
    logic [gda_pkg::YearW-1:0]  sy
  );
    date_result_t r;
    int unsigned  du;
    int unsigned  mu;
    int unsigned  yu;
    int unsigned  sdu;
    int unsigned  smu;
    int unsigned  syu;
    int unsigned  nd;
    int unsigned  nm;
    int unsigned  ny;
    int unsigned  ty;
    int unsigned  doy;
    du  = 32'(d);
    mu  = 32'(m);
    yu  = 32'(y);
    sdu = 32'(sd);
    smu = 32'(sm);
    syu = 32'(sy);
    r.day   = gda_pkg::DayW'(1);
    r.month = gda_pkg::MonthW'(1);
    r.year  = '0;
    r.count = '0;
    nd = du;
    nm = mu;
    ny = yu;
    case (cmd)
      gda_pkg::CMD_NEXT_DAY: begin
        nd = nd + 1;
        if (nd > days_in_month(nm, ny)) begin
          nd = 1;
          nm = nm + 1;
          if (nm > 12) begin
            nm = 1;
            ny = (ny + 1) % YearSpan;
          end
        end
        r.day   = gda_pkg::DayW'(nd);
        r.month = gda_pkg::MonthW'(nm);
        r.year  = gda_pkg::YearW'(ny);
      end
      gda_pkg::CMD_PREV_DAY: begin
        if (nd <= 1) begin
          if (nm <= 1) begin
            nm = 12;
            ny = (ny + YearSpan - 1) % YearSpan;
          end else begin
            nm = nm - 1;
          end
          nd = days_in_month(nm, ny);
        end else begin
          nd = nd - 1;
        end
        r.day   = gda_pkg::DayW'(nd);
        r.month = gda_pkg::MonthW'(nm);
        r.year  = gda_pkg::YearW'(ny);
      end
      gda_pkg::CMD_WEEK: begin
        doy = ordinal_day(du, mu, yu);
        r.count = (doy == 0) ? gda_pkg::CountW'(1) :
                               gda_pkg::CountW'((doy - 1) / 7 + 1);
      end
      gda_pkg::CMD_DIST: begin
        r.count = day_gap(day_number(du, mu, yu), day_number(sdu, smu, syu));
      end
      gda_pkg::CMD_ANNIV: begin
        // on or before today moves to next year, no year wrap here
        ty = yu;
        if (ordinal_day(sdu, smu, yu) <= ordinal_day(du, mu, yu)) begin
          ty = ty + 1;
        end
        r.count = day_gap(day_number(du, mu, yu), day_number(sdu, smu, ty));
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    date_result_t got;
    date_result_t want;
    if (rst_ni) begin
      if (req_i.valid && req_i.ready) begin
        calendar_results_q.push_back(predict_calendar(
          req_i.cmd, req_i.date_day, req_i.date_month, req_i.date_year,
          req_i.second_day, req_i.second_month, req_i.second_year));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.day   = rsp_i.out_day;
        got.month = rsp_i.out_month;
        got.year  = rsp_i.out_year;
        got.count = rsp_i.out_count;
        if (calendar_results_q.size() == 0) begin
          report_mismatch("response transfer with no request outstanding");
        end else begin
          want = calendar_results_q.pop_front();
          check_field("out_day", 32'(got.day), 32'(want.day));
          check_field("out_month", 32'(got.month), 32'(want.month));
          check_field("out_year", 32'(got.year), 32'(want.year));
          check_field("out_count", 32'(got.count), 32'(want.count));
        end
      end
      outstanding = calendar_results_q.size();
    end
  end

endmodule

@@ bench/gregorian_date_arithmetic_tb.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_tb
// Testbench top for the Gregorian date unit. It drives directed corner dates
// and then random requests through phases of sender idling and receiver
// stalling, including one long receiver hold that backs the pipeline up.
// A checker beside the unit predicts and compares; this module gives the
// verdict once every response has come back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module gregorian_date_arithmetic_tb;

  localparam logic [gda_pkg::CmdW-1:0]  CmdSpareLo = gda_pkg::CMD_ANNIV + 3'd1;
  localparam logic [gda_pkg::CmdW-1:0]  CmdSpareHi = '1;
  localparam logic [gda_pkg::YearW-1:0] YearMax    = '1;
  localparam int unsigned               SegItems   = 150;
  localparam int unsigned               HoldCycles = 400;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic rsp_ready = 1'b0;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int          errors;
  int          pending;

  gda_req_if req_if ();
  gda_rsp_if rsp_if ();

  assign rsp_if.ready = rsp_ready;

  gregorian_date_arithmetic u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  gregorian_date_arithmetic_checker u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .rsp_i     (rsp_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, plus a long hold on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
    end else if (hold_left != 0) begin
      rsp_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_req(input logic [gda_pkg::CmdW-1:0] c,
                          input logic [gda_pkg::DayW-1:0] d,
                          input logic [gda_pkg::MonthW-1:0] m,
                          input logic [gda_pkg::YearW-1:0] y,
                          input logic [gda_pkg::DayW-1:0] sd,
                          input logic [gda_pkg::MonthW-1:0] sm,
                          input logic [gda_pkg::YearW-1:0] sy);
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= c;
    req_if.date_day     <= d;
    req_if.date_month   <= m;
    req_if.date_year    <= y;
    req_if.second_day   <= sd;
    req_if.second_month <= sm;
    req_if.second_year  <= sy;
    do @(posedge clk); while (!req_if.ready);
  endtask

  // mostly valid dates, weighted to month ends, centuries and year extremes
  task automatic pick_date(output logic [gda_pkg::DayW-1:0] d,
                           output logic [gda_pkg::MonthW-1:0] m,
                           output logic [gda_pkg::YearW-1:0] y);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 65) begin
      y = gda_pkg::YearW'($urandom_range(9999, 1));
    end else if (sel < 82) begin
      y = gda_pkg::YearW'(100 * $urandom_range(99, 1));
    end else if (sel < 90) begin
      y = ($urandom_range(1) != 0) ? YearMax - gda_pkg::YearW'($urandom_range(2)) :
                                     gda_pkg::YearW'($urandom_range(1));
    end else begin
      y = gda_pkg::YearW'($urandom_range(32'(YearMax), 0));
    end
    m = ($urandom_range(99) < 90) ? gda_pkg::MonthW'($urandom_range(12, 1)) :
                                    gda_pkg::MonthW'($urandom_range(15, 0));
    sel = $urandom_range(99);
    if (sel < 20) begin
      d = 1;
    end else if (sel < 55) begin
      d = gda_pkg::DayW'($urandom_range(28, 1));
    end else if (sel < 90) begin
      d = gda_pkg::DayW'($urandom_range(31, 28));
    end else begin
      d = gda_pkg::DayW'($urandom_range(31, 0));
    end
  endtask

  initial begin
    logic [gda_pkg::CmdW-1:0]   c;
    logic [gda_pkg::DayW-1:0]   d;
    logic [gda_pkg::DayW-1:0]   sd;
    logic [gda_pkg::MonthW-1:0] m;
    logic [gda_pkg::MonthW-1:0] sm;
    logic [gda_pkg::YearW-1:0]  y;
    logic [gda_pkg::YearW-1:0]  sy;
    int unsigned                seg;
    int unsigned                n;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= gda_pkg::CMD_NEXT_DAY;
    req_if.date_day     <= '0;
    req_if.date_month   <= '0;
    req_if.date_year    <= '0;
    req_if.second_day   <= '0;
    req_if.second_month <= '0;
    req_if.second_year  <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // stepping across month, year, leap and wrap boundaries
    send_req(gda_pkg::CMD_NEXT_DAY, 31, 12, 9999, 1, 1, 1);
    send_req(gda_pkg::CMD_PREV_DAY, 1, 1, 1, 1, 1, 1);
    send_req(gda_pkg::CMD_NEXT_DAY, 28, 2, 2000, 1, 1, 1);
    send_req(gda_pkg::CMD_NEXT_DAY, 28, 2, 1900, 1, 1, 1);
    send_req(gda_pkg::CMD_PREV_DAY, 1, 3, 2024, 1, 1, 1);
    send_req(gda_pkg::CMD_PREV_DAY, 1, 3, 2100, 1, 1, 1);
    send_req(gda_pkg::CMD_NEXT_DAY, 31, 12, YearMax, 31, 15, YearMax);
    send_req(gda_pkg::CMD_PREV_DAY, 1, 1, 0, 0, 0, 0);
    send_req(gda_pkg::CMD_NEXT_DAY, 31, 13, 5, 1, 1, 1);
    send_req(gda_pkg::CMD_NEXT_DAY, 31, 15, 5, 1, 1, 1);
    send_req(gda_pkg::CMD_PREV_DAY, 0, 5, 2000, 1, 1, 1);
    send_req(gda_pkg::CMD_PREV_DAY, 0, 0, 0, 0, 0, 0);
    send_req(gda_pkg::CMD_NEXT_DAY, 0, 0, 0, 0, 0, 0);
    // week number, distance, anniversary and spare codes
    send_req(gda_pkg::CMD_WEEK, 0, 1, 2000, 1, 1, 1);
    send_req(gda_pkg::CMD_WEEK, 31, 12, 2000, 1, 1, 1);
    send_req(gda_pkg::CMD_WEEK, 31, 15, 2000, 1, 1, 1);
    send_req(gda_pkg::CMD_DIST, 1, 1, 1, 31, 12, 9999);
    send_req(gda_pkg::CMD_DIST, 1, 1, 0, 31, 15, YearMax);
    send_req(gda_pkg::CMD_DIST, 15, 6, 2024, 15, 6, 2024);
    send_req(gda_pkg::CMD_ANNIV, 10, 4, 2023, 10, 4, 1);
    send_req(gda_pkg::CMD_ANNIV, 1, 1, 2023, 29, 2, 1);
    send_req(gda_pkg::CMD_ANNIV, 31, 12, YearMax, 1, 1, 0);
    send_req(gda_pkg::CMD_ANNIV, 1, 1, 0, 31, 15, YearMax);
    send_req(CmdSpareLo, 31, 15, YearMax, 31, 15, YearMax);
    send_req(CmdSpareHi, 31, 15, YearMax, 31, 15, YearMax);

    for (seg = 0; seg < 6; seg++) begin
      case (seg % 4)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 67;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 67;
        end
        default: begin
          idle_pct  = 8;
          stall_pct = 8;
        end
      endcase
      for (n = 0; n < SegItems; n++) begin
        // long receiver hold while the sender keeps offering
        if (seg == 4 && n == 20) begin
          hold_req++;
        end
        pick_date(d, m, y);
        pick_date(sd, sm, sy);
        c = ($urandom_range(99) < 4) ?
            gda_pkg::CmdW'($urandom_range(32'(CmdSpareHi), 32'(CmdSpareLo))) :
            gda_pkg::CmdW'($urandom_range(32'(gda_pkg::CMD_ANNIV),
                                          32'(gda_pkg::CMD_NEXT_DAY)));
        if ($urandom_range(99) < 25) begin
          sd = d;
          sm = m;
        end
        if ($urandom_range(99) < 20) begin
          sy = y;
        end
        send_req(c, d, m, y, sd, sm, sy);
      end
    end

    req_if.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #200_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
